/* design/iag_pkg.sv */
// Shared types and constants for the impact attenuation gain core.
// Used by iag_regs, iag_ctrl, iag_datapath and the top level.
package iag_pkg;

	localparam int AccelW   = 16;
	localparam int SetptW   = 11;
	localparam int GainW    = 16;
	localparam int LevelW   = 13;
	localparam int AuthW    = 13;
	localparam int AccW     = 32;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// Quotient bits produced by the serial divider (authority reaches 4096)
	localparam int DivSteps = 13;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	localparam logic [AuthW-1:0] AuthOne = AuthW'(4096);
	localparam logic [GainW-1:0] GainReset = GainW'(4096);

	localparam logic [CfgIdxW-1:0] RegFilterGain  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegAccelThr    = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] RegSetptThr    = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] RegHpStart     = CfgIdxW'(3);
	localparam logic [CfgIdxW-1:0] RegHpEnd       = CfgIdxW'(4);

	typedef struct packed {
		logic [GainW-1:0]  filter_gain;
		logic [LevelW-1:0] accel_threshold;
		logic [SetptW-1:0] setpoint_threshold;
		logic [LevelW-1:0] highpass_start;
		logic [LevelW-1:0] highpass_end;
		logic              gain_wr;
	} iag_cfg_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic upd;
		logic hp;
		logic prep;
		logic div_step;
		logic fin;
		logic load_out;
	} iag_cmd_t;

	typedef struct packed {
		logic need_div;
	} iag_sts_t;

endpackage

/* design/iag_regs.sv */
// Configuration register file of the impact attenuation gain core.
// Depends on iag_pkg.
module iag_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [iag_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [iag_pkg::CfgDataW-1:0] cfg_data,
	output iag_pkg::iag_cfg_t             cfg
);
	import iag_pkg::*;

	logic [GainW-1:0]  gain_q;
	logic [LevelW-1:0] accel_thr_q;
	logic [SetptW-1:0] setpt_thr_q;
	logic [LevelW-1:0] hp_start_q;
	logic [LevelW-1:0] hp_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GainReset;
			accel_thr_q <= '0;
			setpt_thr_q <= '0;
			hp_start_q  <= '0;
			hp_end_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				RegFilterGain: gain_q      <= cfg_data[GainW-1:0];
				RegAccelThr:   accel_thr_q <= cfg_data[LevelW-1:0];
				RegSetptThr:   setpt_thr_q <= cfg_data[SetptW-1:0];
				RegHpStart:    hp_start_q  <= cfg_data[LevelW-1:0];
				RegHpEnd:      hp_end_q    <= cfg_data[LevelW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.filter_gain        = gain_q;
	assign cfg.accel_threshold    = accel_thr_q;
	assign cfg.setpoint_threshold = setpt_thr_q;
	assign cfg.highpass_start     = hp_start_q;
	assign cfg.highpass_end       = hp_end_q;
	// a gain write re-primes the filter on the next sample
	assign cfg.gain_wr            = cfg_wr_en && (cfg_index == RegFilterGain);

endmodule

/* design/iag_ctrl.sv */
// Sequencer of the impact attenuation gain core: walks one word through
// filter, gate, optional divide and output. Depends on iag_pkg.
module iag_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  iag_pkg::iag_sts_t sts,
	output iag_pkg::iag_cmd_t cmd
);
	import iag_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_UPD,
		S_HP,
		S_PREP,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [DivCntW-1:0]  div_cnt_q;
	logic                out_full_q;
	logic                slot_free;

	assign slot_free = !out_full_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_full_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load_in  = in_valid;
			S_MUL:  cmd.mul      = 1'b1;
			S_UPD:  cmd.upd      = 1'b1;
			S_HP:   cmd.hp       = 1'b1;
			S_PREP: cmd.prep     = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_FIN:  cmd.fin      = 1'b1;
			S_OUT:  cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			div_cnt_q  <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_full_q <= 1'b1;
			end else if (!out_stall) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL;
				S_MUL:  state_q <= S_UPD;
				S_UPD:  state_q <= S_HP;
				S_HP:   state_q <= S_PREP;
				S_PREP: begin
					div_cnt_q <= '0;
					state_q   <= sts.need_div ? S_DIV : S_OUT;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DivCntW'(1);
					if (div_cnt_q == DivCntW'(DivSteps - 1)) state_q <= S_FIN;
				end
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/iag_datapath.sv */
// Datapath of the impact attenuation gain core: low-pass filter, high-pass
// magnitude, gating, serial divider and output word. Depends on iag_pkg.
module iag_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iag_pkg::iag_cfg_t           cfg,
	input  iag_pkg::iag_cmd_t           cmd,
	output iag_pkg::iag_sts_t           sts,
	input  logic [iag_pkg::AccelW-1:0] accel_mag,
	input  logic [iag_pkg::SetptW-1:0] max_setpoint,
	input  logic                        enable,
	output logic [iag_pkg::AuthW-1:0]  authority,
	output logic [iag_pkg::AccelW-1:0] filtered_accel,
	output logic [iag_pkg::AccelW-1:0] highpass_accel
);
	import iag_pkg::*;

	localparam int LvlW  = LevelW + 4;   // level times ten
	localparam int WideW = AccW + 1;     // Q17.16 levels reach past 32 bits
	localparam int ProdW = AccW + GainW;
	localparam int NumW  = WideW + 12 + 1;

	// filter state
	logic [AccW-1:0]    acc_q;
	logic               primed_q;

	// captured word
	logic [AccelW-1:0]  x_q;
	logic [SetptW-1:0]  sp_q;
	logic               en_q;

	logic [ProdW-1:0]   prod_q;
	logic               up_q;
	logic [AccW-1:0]    hp_q;
	logic               gate_q;
	logic [AuthW-1:0]   auth_q;
	logic [WideW-1:0]   den_q;
	logic [WideW-1:0]   rem_q;
	logic [DivSteps-1:0] quo_q;

	logic [AuthW-1:0]   out_auth_q;
	logic [AccelW-1:0]  out_filt_q;
	logic [AccelW-1:0]  out_hp_q;

	logic [AccW-1:0]    xq;
	logic [AccW-1:0]    base;
	logic [AccW-1:0]    diff;
	logic [AccW-1:0]    step;
	logic [ProdW-1:0]   step_wide;
	logic [LvlW-1:0]    thr;
	logic [LvlW-1:0]    s_lvl;
	logic [LvlW-1:0]    e_lvl;
	logic [WideW-1:0]   s_q16;
	logic [WideW-1:0]   e_q16;
	logic [WideW-1:0]   hp_wide;
	logic [WideW-1:0]   hp_off;
	logic [WideW-1:0]   den;
	logic [NumW-1:0]    num;
	logic [WideW:0]     trial;
	logic               trial_ge;
	logic [AccW:0]      acc_rnd;
	logic [AccW:0]      hp_rnd;

	assign xq    = {x_q, 16'b0};
	assign base  = primed_q ? acc_q : xq;
	assign diff  = (xq >= base) ? (xq - base) : (base - xq);

	assign step_wide = prod_q + ProdW'(32768);
	assign step      = step_wide[ProdW-1:16];

	// levels in hundredths of g to milli-g: times ten
	assign thr   = (LvlW'(cfg.accel_threshold) << 3) + (LvlW'(cfg.accel_threshold) << 1);
	assign s_lvl = (LvlW'(cfg.highpass_start) << 3) + (LvlW'(cfg.highpass_start) << 1);
	assign e_lvl = (LvlW'(cfg.highpass_end) << 3) + (LvlW'(cfg.highpass_end) << 1);
	assign s_q16 = {s_lvl, 16'b0};
	assign e_q16 = {e_lvl, 16'b0};

	assign hp_wide = {1'b0, hp_q};
	assign hp_off  = hp_wide - s_q16;
	assign den     = e_q16 - s_q16;
	assign num     = NumW'({hp_off, 12'b0}) + NumW'(den >> 1);

	assign sts.need_div = gate_q && (hp_wide > s_q16) && (hp_wide < e_q16);

	assign trial    = {rem_q, quo_q[DivSteps-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	assign acc_rnd = {1'b0, acc_q} + (AccW+1)'(32768);
	assign hp_rnd  = {1'b0, hp_q} + (AccW+1)'(32768);

	// filter state and prime flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			if (cmd.mul) begin
				acc_q    <= base;
				primed_q <= 1'b1;
			end else if (cmd.upd) begin
				acc_q <= up_q ? (acc_q + step) : (acc_q - step);
			end
			if (cfg.gain_wr) primed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q  <= accel_mag;
			sp_q <= max_setpoint;
			en_q <= enable;
		end
		if (cmd.mul) begin
			prod_q <= ProdW'(diff) * ProdW'(cfg.filter_gain);
			up_q   <= (xq >= base);
		end
		if (cmd.hp) begin
			hp_q   <= (xq >= acc_q) ? (xq - acc_q) : (acc_q - xq);
			gate_q <= en_q && (sp_q < cfg.setpoint_threshold)
				&& ((LvlW'(x_q) > thr) || ({1'b0, acc_q} > {thr, 16'b0}))
				&& (cfg.highpass_end > cfg.highpass_start);
		end
		if (cmd.prep) begin
			den_q <= den;
			rem_q <= num[NumW-1:DivSteps];
			quo_q <= num[DivSteps-1:0];
			if (gate_q && (hp_wide >= e_q16)) begin
				auth_q <= '0;
			end else begin
				auth_q <= AuthOne;
			end
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? WideW'(trial - {1'b0, den_q}) : trial[WideW-1:0];
			quo_q <= {quo_q[DivSteps-2:0], trial_ge};
		end
		if (cmd.fin) begin
			auth_q <= (quo_q >= AuthOne) ? '0 : (AuthOne - quo_q);
		end
		if (cmd.load_out) begin
			out_auth_q <= auth_q;
			out_filt_q <= acc_rnd[AccW] ? '1 : acc_rnd[AccW-1:16];
			out_hp_q   <= hp_rnd[AccW] ? '1 : hp_rnd[AccW-1:16];
		end
	end

	assign authority      = out_auth_q;
	assign filtered_accel = out_filt_q;
	assign highpass_accel = out_hp_q;

endmodule

/* design/impact_attenuation_gain_core.sv */
// Top level of the impact attenuation gain core.
// Instantiates iag_regs, iag_ctrl and iag_datapath; depends on iag_pkg.
//
//   port group   direction  handshake           payload
//   in           to core    in_valid/in_stall   accel_mag, max_setpoint, enable
//   out          from core  out_valid/out_stall authority, filtered_accel,
//                                                highpass_accel
//   cfg          to core    cfg_wr_en           cfg_index, cfg_data
//
// One word at a time, through the single 32x16 multiplier and, when authority
// falls inside the ramp, the 13-step shift-and-subtract divider; the next word
// is taken only after the current one is loaded into the output register.
// Reset clears the filter, the prime flag and all control state, and loads
// the register reset values. A finished word waits in the output register
// while the next input word is taken; a stalled output holds the sequencer
// in its last state until the output register frees.
module impact_attenuation_gain_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [iag_pkg::AccelW-1:0]   accel_mag,
	input  logic [iag_pkg::SetptW-1:0]   max_setpoint,
	input  logic                          enable,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [iag_pkg::AuthW-1:0]    authority,
	output logic [iag_pkg::AccelW-1:0]   filtered_accel,
	output logic [iag_pkg::AccelW-1:0]   highpass_accel,
	input  logic                          cfg_wr_en,
	input  logic [iag_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [iag_pkg::CfgDataW-1:0] cfg_data
);
	import iag_pkg::*;

	iag_cfg_t cfg;
	iag_cmd_t cmd;
	iag_sts_t sts;

	iag_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	iag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	iag_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.accel_mag      (accel_mag),
		.max_setpoint   (max_setpoint),
		.enable         (enable),
		.authority      (authority),
		.filtered_accel (filtered_accel),
		.highpass_accel (highpass_accel)
	);

endmodule

/* verif/tb_impact_attenuation_gain_core.sv */
// Self-checking testbench for impact_attenuation_gain_core.
// Depends on iag_pkg and the core RTL; predicts each output word as its input word is taken.
module tb_impact_attenuation_gain_core;
	timeunit 1ns;
	timeprecision 1ps;
	import iag_pkg::*;

	localparam int SettleCycles = 40;
	localparam int LongHold     = 300;
	localparam int DrainLimit   = 20000;
	localparam int SetWords     = 150;

	typedef struct packed {
		logic [AuthW-1:0]  authority;
		logic [AccelW-1:0] filtered;
		logic [AccelW-1:0] highpass;
	} attn_word_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [AccelW-1:0]   accel_mag;
	logic [SetptW-1:0]   max_setpoint;
	logic                enable;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [AuthW-1:0]    authority;
	logic [AccelW-1:0]   filtered_accel;
	logic [AccelW-1:0]   highpass_accel;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// predicted register contents and filter state
	logic [GainW-1:0]  gain_q16;
	logic [LevelW-1:0] accel_gate;
	logic [SetptW-1:0] setpt_gate;
	logic [LevelW-1:0] ramp_start;
	logic [LevelW-1:0] ramp_end;
	logic [AccW-1:0]   lp_acc;
	logic              lp_primed;

	attn_word_t        attn_q[$];
	int unsigned       bad_words;
	int unsigned       reported;
	int unsigned       src_idle_pct;
	int unsigned       sink_stall_pct;
	int unsigned       hold_req;
	int unsigned       hold_ack = 0;
	int unsigned       hold_left = 0;
	int                walk_centre;
	int                walk_span;
	logic [AccelW-1:0] prev_sample;

	impact_attenuation_gain_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [AccelW-1:0] to_milli(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd32768) >> 16;
		return (r > 64'd65535) ? '1 : r[AccelW-1:0];
	endfunction

	function automatic attn_word_t attenuate_sample(input logic [AccelW-1:0] x,
			input logic [SetptW-1:0] sp, input logic en);
		logic [63:0] xq, acc, delta, hp, thr, lo, hi, den, q;
		attn_word_t w;
		xq = 64'(x) << 16;
		if (!lp_primed) begin
			lp_acc = xq[AccW-1:0];
			lp_primed = 1'b1;
		end
		acc = 64'(lp_acc);
		// step towards the sample by the rounded share of the gap, never past it
		if (xq >= acc) begin
			delta = ((xq - acc) * 64'(gain_q16) + 64'd32768) >> 16;
			acc = acc + delta;
		end else begin
			delta = ((acc - xq) * 64'(gain_q16) + 64'd32768) >> 16;
			acc = acc - delta;
		end
		lp_acc = acc[AccW-1:0];
		hp = (xq >= acc) ? xq - acc : acc - xq;
		// levels are hundredths of g, ten milli-g each
		thr = 64'(accel_gate) * 64'd10;
		w.authority = AuthOne;
		if (en && sp < setpt_gate && (64'(x) > thr || acc > (thr << 16))) begin
			lo = (64'(ramp_start) * 64'd10) << 16;
			hi = (64'(ramp_end) * 64'd10) << 16;
			if (hi > lo) begin
				if (hp >= hi) begin
					w.authority = '0;
				end else if (hp > lo) begin
					den = hi - lo;
					q = ((hp - lo) * 64'(AuthOne) + den / 2) / den;
					w.authority = (q >= 64'(AuthOne)) ? '0 : AuthOne - AuthW'(q);
				end
			end
		end
		w.filtered = to_milli(acc);
		w.highpass = to_milli(hp);
		return w;
	endfunction

	task automatic flag_word(input string what, input attn_word_t exp_w, input attn_word_t got_w);
		bad_words++;
		if (reported < 10) begin
			reported++;
			$display("%0t %s: authority %0d/%0d filtered %0d/%0d highpass %0d/%0d (exp/got)",
				$time, what, exp_w.authority, got_w.authority, exp_w.filtered,
				got_w.filtered, exp_w.highpass, got_w.highpass);
		end
	endtask

	// output side: check each word taken, then pick the stall for the next cycle
	always @(posedge clk) begin : drain_side
		attn_word_t got_w;
		if (arst_n && out_valid && !out_stall) begin
			got_w = {authority, filtered_accel, highpass_accel};
			if (attn_q.size() == 0) begin
				flag_word("word with none pending", '0, got_w);
			end else if (got_w !== attn_q[0]) begin
				flag_word("mismatch", attn_q.pop_front(), got_w);
			end else begin
				void'(attn_q.pop_front());
			end
		end
		if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = LongHold;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	task automatic send_sample(input logic [AccelW-1:0] a, input logic [SetptW-1:0] sp,
			input logic en);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		accel_mag <= a;
		max_setpoint <= sp;
		enable <= en;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		attn_q.push_back(attenuate_sample(a, sp, en));
	endtask

	// drop valid and hold until every pending word is out, then let the core settle
	task automatic wait_drained();
		int unsigned n;
		in_valid <= 1'b0;
		n = 0;
		while (attn_q.size() != 0 && n < DrainLimit) begin
			@(posedge clk);
			n++;
		end
		while (attn_q.size() != 0) flag_word("word never came", attn_q.pop_front(), '0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			RegFilterGain: begin
				gain_q16 = d;
				lp_primed = 1'b0;
			end
			RegAccelThr: accel_gate = d[LevelW-1:0];
			RegSetptThr: setpt_gate = d[SetptW-1:0];
			RegHpStart:  ramp_start = d[LevelW-1:0];
			RegHpEnd:    ramp_end = d[LevelW-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic randomise_regs();
		logic [CfgDataW-1:0] g, lo, hi;
		wait_drained();
		if ($urandom_range(1)) begin
			case ($urandom_range(5))
				0: g = '0;
				1: g = CfgDataW'(1);
				2: g = '1;
				3: g = GainReset;
				4: g = CfgDataW'($urandom_range(256, 8192));
				default: g = CfgDataW'($urandom);
			endcase
			write_reg(RegFilterGain, g);
		end
		case ($urandom_range(5))
			0: write_reg(RegAccelThr, '0);
			1: write_reg(RegAccelThr, '1);
			2: write_reg(RegAccelThr, CfgDataW'($urandom));
			default: write_reg(RegAccelThr, CfgDataW'($urandom_range(400)));
		endcase
		case ($urandom_range(5))
			0: write_reg(RegSetptThr, '0);
			1: write_reg(RegSetptThr, CfgDataW'(2047));
			2: write_reg(RegSetptThr, CfgDataW'(2000));
			default: write_reg(RegSetptThr, CfgDataW'($urandom_range(200, 2047)));
		endcase
		case ($urandom_range(5))
			0: begin
				lo = '0;
				hi = CfgDataW'(8191);
			end
			1: begin
				lo = CfgDataW'($urandom_range(300));
				hi = CfgDataW'($urandom_range(lo));
			end
			2: begin
				lo = CfgDataW'($urandom);
				hi = CfgDataW'($urandom);
			end
			default: begin
				lo = CfgDataW'($urandom_range(300));
				hi = lo + CfgDataW'($urandom_range(1, 600));
			end
		endcase
		write_reg(RegHpStart, lo);
		write_reg(RegHpEnd, hi);
		if ($urandom_range(3) == 0)
			write_reg(CfgIdxW'(RegHpEnd + $urandom_range(1, 3)), CfgDataW'($urandom));
		walk_span = int'(ramp_end) * 20 + 200;
		if (walk_span > 30000)
			walk_span = 30000;
		walk_centre = $urandom_range(2000, 20000);
	endtask

	// mostly a wander around a centre sized to the ramp, with jumps, rails and repeats
	task automatic send_random_sample();
		int                v;
		int unsigned       pick;
		logic [SetptW-1:0] sp;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 3)
			walk_centre = $urandom_range(30000);
		if (pick < 60) begin
			v = walk_centre + int'($urandom_range(2 * walk_span)) - walk_span;
			prev_sample = (v < 0) ? '0 : (v > 65535) ? '1 : AccelW'(v);
		end else if (pick < 75) begin
			prev_sample = AccelW'($urandom);
		end else if (pick < 85) begin
			prev_sample = $urandom_range(1) ? '1 : '0;
		end
		if (setpt_gate != 0 && $urandom_range(99) < 70)
			sp = SetptW'($urandom_range(setpt_gate - 1));
		else
			sp = SetptW'($urandom);
		send_sample(prev_sample, sp, $urandom_range(99) < 85);
	endtask

	task automatic test_power_on_defaults();
		// setpoint gate is zero out of reset, so authority stays full
		send_sample(AccelW'(1000), '0, 1'b1);
		send_sample('1, '1, 1'b1);
		send_sample('0, '0, 1'b0);
	endtask

	task automatic test_gate_and_ramp();
		wait_drained();
		write_reg(RegFilterGain, GainReset);
		write_reg(RegAccelThr, CfgDataW'(50));
		write_reg(RegSetptThr, CfgDataW'(1000));
		write_reg(RegHpStart, '0);
		write_reg(RegHpEnd, CfgDataW'(10));
		send_sample(AccelW'(300), '0, 1'b1);
		// sample and filter both at or below the gate
		send_sample(AccelW'(400), '0, 1'b1);
		send_sample(AccelW'(500), '0, 1'b1);
		send_sample(AccelW'(900), '0, 1'b1);
		wait_drained();
		write_reg(RegHpStart, CfgDataW'(100));
		write_reg(RegHpEnd, CfgDataW'(300));
		send_sample(AccelW'(3000), SetptW'(999), 1'b1);
		send_sample(AccelW'(3000), SetptW'(1000), 1'b1);
		send_sample(AccelW'(3000), SetptW'(999), 1'b0);
		send_sample(AccelW'(20000), '0, 1'b1);
		// zero sample: gate held open by the filter alone
		send_sample('0, '0, 1'b1);
	endtask

	task automatic test_empty_span_and_wide_levels();
		wait_drained();
		write_reg(RegHpStart, CfgDataW'(200));
		write_reg(RegHpEnd, CfgDataW'(200));
		send_sample(AccelW'(9000), '0, 1'b1);
		wait_drained();
		write_reg(RegHpEnd, CfgDataW'(100));
		send_sample(AccelW'(200), '0, 1'b1);
		wait_drained();
		write_reg(RegAccelThr, '1);
		write_reg(RegHpStart, '0);
		write_reg(RegHpEnd, '1);
		write_reg(RegSetptThr, '1);
		send_sample('1, '0, 1'b1);
		wait_drained();
		write_reg(RegAccelThr, '0);
		send_sample('0, SetptW'(2046), 1'b1);
		send_sample(AccelW'(40000), '1, 1'b1);
	endtask

	task automatic test_gain_extremes();
		wait_drained();
		write_reg(RegFilterGain, '0);
		send_sample(AccelW'(1234), '0, 1'b1);
		send_sample(AccelW'(60000), '0, 1'b1);
		wait_drained();
		write_reg(RegFilterGain, '1);
		send_sample(AccelW'(100), '0, 1'b1);
		send_sample('1, '0, 1'b1);
		send_sample('0, '0, 1'b1);
		wait_drained();
		write_reg(RegFilterGain, CfgDataW'(1));
		send_sample(AccelW'(5), '0, 1'b1);
	endtask

	task automatic test_unused_indexes();
		wait_drained();
		write_reg(CfgIdxW'(RegHpEnd + 1), '1);
		write_reg(CfgIdxW'(RegHpEnd + 2), '1);
		write_reg(CfgIdxW'(RegHpEnd + 3), '1);
		// filter must carry on without a reprime
		send_sample(AccelW'(30000), '0, 1'b1);
		send_sample(AccelW'(30001), '0, 1'b1);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req++;
		repeat (12) send_random_sample();
		wait_drained();
	endtask

	task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
			input int unsigned words);
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < words; i++) begin
			if (i % SetWords == 0)
				randomise_regs();
			else if (i % SetWords == SetWords / 2)
				wait_drained();
			send_random_sample();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		accel_mag = '0;
		max_setpoint = '0;
		enable = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gain_q16 = GainReset;
		accel_gate = '0;
		setpt_gate = '0;
		ramp_start = '0;
		ramp_end = '0;
		lp_acc = '0;
		lp_primed = 1'b0;
		bad_words = 0;
		reported = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_req = 0;
		walk_centre = 8000;
		walk_span = 2000;
		prev_sample = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_defaults();
		test_gate_and_ramp();
		test_empty_span_and_wide_levels();
		test_gain_extremes();
		test_unused_indexes();
		test_random_phase(37, 57, 600);
		test_output_backpressure();
		test_random_phase(57, 37, 600);
		test_random_phase(0, 0, 500);
		wait_drained();
		if (bad_words == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
